// File: rtl/aga_pkg.sv
package aga_pkg;

  localparam int unsigned MAX_LEN_DEF    = 32;
  localparam int unsigned SCORE_BITS_DEF = 16;

  localparam logic [7:0] GAP_CHAR = 8'd45;

  typedef enum logic [1:0] {
    OP_TARGET = 2'd0,
    OP_QUERY  = 2'd1,
    OP_ALIGN  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_MATCH    = 3'd0,
    CFG_MISMATCH = 3'd1,
    CFG_GAP_OPEN = 3'd2,
    CFG_GAP_EXT  = 3'd3,
    CFG_PARTIAL  = 3'd4,
    CFG_IUPAC    = 3'd5
  } cfg_e;

  typedef enum logic [1:0] {
    PAIR_MATCH    = 2'd0,
    PAIR_PARTIAL  = 2'd1,
    PAIR_MISMATCH = 2'd2
  } pair_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] base;
  } in_t;

  typedef struct packed {
    logic [7:0] query_column;
    logic [7:0] target_column;
    logic       last_column;
  } out_t;

  // Two-base IUPAC code holding the other base.
  function automatic logic is_partial(input logic [7:0] code, input logic [7:0] b);
    logic r;
    r = 1'b0;
    case (code)
      "R": r = (b == "A") || (b == "G");
      "Y": r = (b == "C") || (b == "T");
      "S": r = (b == "G") || (b == "C");
      "W": r = (b == "A") || (b == "T");
      "K": r = (b == "G") || (b == "T");
      "M": r = (b == "A") || (b == "C");
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic pair_e pair_class(input logic [7:0] t, input logic [7:0] q,
                                       input logic iupac);
    pair_e r;
    if (t == q) begin
      r = PAIR_MATCH;
    end else if (iupac && (is_partial(t, q) || is_partial(q, t))) begin
      r = PAIR_PARTIAL;
    end else begin
      r = PAIR_MISMATCH;
    end
    return r;
  endfunction

endpackage

// File: rtl/aga_ram.sv
module aga_ram #(
  parameter int unsigned AW    = 5,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/affine_gap_global_aligner.sv
// Global aligner with affine gaps (match table plus one merged gap table).
// Input channel (in_valid_i / in_stall_o, word in_data_i): op TARGET or QUERY
// appends one base to its store; bases past MAX_LEN are dropped.
// op ALIGN fills both score tables and traces back, then sends the aligned
// columns, first column first, on the output channel (out_valid_o /
// out_stall_i, word out_data_o); last_column marks the final word.
// An align fills the (nq+1)*(nt+1) table cells, seeds the traceback, runs its
// steps, each reading two table words and writing one column, closes it, and
// reads, loads and sends each output word as the receiver takes it.
// Each cell costs one read and one write of the table memory, which sets the
// fill rate. One item is worked on at a time: in_stall_o stays high from an
// align until its last word is taken. A stall holds the output word and the
// emit sequence.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered and
// are to be made only while the block is idle.
// Reset clears the base counts, the control state and restores the default
// scores; stores and tables need no clearing, every entry is written before
// its value is used.
module affine_gap_global_aligner #(
  parameter int unsigned MAX_LEN    = aga_pkg::MAX_LEN_DEF,
  parameter int unsigned SCORE_BITS = aga_pkg::SCORE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  aga_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output aga_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i
);

  localparam int unsigned SB    = SCORE_BITS;
  localparam int unsigned DIM   = MAX_LEN + 1;
  localparam int unsigned AW    = $clog2(DIM * DIM);
  localparam int unsigned LW    = $clog2(MAX_LEN + 1);
  localparam int unsigned SAW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CAW   = $clog2(2 * MAX_LEN);

  localparam logic signed [SB-1:0] SMIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SMAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SZERO = '0;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_FILL_RD = 11'b000_0000_0010,
    S_FILL_WR = 11'b000_0000_0100,
    S_TB_INIT = 11'b000_0000_1000,
    S_TB_SEED = 11'b000_0001_0000,
    S_TB_RD1  = 11'b000_0010_0000,
    S_TB_RD2  = 11'b000_0100_0000,
    S_TB_STEP = 11'b000_1000_0000,
    S_EM_RD   = 11'b001_0000_0000,
    S_EM_LD   = 11'b010_0000_0000,
    S_EM_OUT  = 11'b100_0000_0000
  } state_e;

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [7:0] b);
    logic signed [SB:0] s;
    logic signed [SB-1:0] r;
    s = {a[SB-1], a} + {{(SB-7){b[7]}}, b};
    if (a == SMIN) begin
      r = SMIN;
    end else if (s[SB] != s[SB-1]) begin
      r = s[SB] ? SMIN : SMAX;
    end else begin
      r = s[SB-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] max2(input logic signed [SB-1:0] a,
                                                input logic signed [SB-1:0] b);
    return (a >= b) ? a : b;
  endfunction

  state_e state_q, state_d;

  // Configuration registers
  logic signed [7:0] match_q, mismatch_q, open_q, ext_q, partial_q;
  logic              iupac_q;

  logic [LW-1:0] tcount_q, qcount_q;
  logic [LW-1:0] ni_q, nj_q;
  logic [LW-1:0] fi_q, fj_q;
  logic [AW-1:0] rb_q;
  logic signed [SB-1:0] lm_q, lg_q, dm_q, dg_q;

  logic [LW-1:0]  ti_q, tj_q;
  logic [AW-1:0]  tc_q;
  logic           inm_q;
  logic [CAW:0]   n_q;
  logic [CAW-1:0] k_q;
  logic signed [SB-1:0] r1m_q, r1g_q;
  logic [7:0]     qb_q, tb_q;

  logic          out_valid_q;
  aga_pkg::out_t out_q;

  // Memory ports
  logic            tbl_we;
  logic [AW-1:0]   tbl_waddr, tbl_raddr;
  logic [2*SB-1:0] tbl_wdata, tbl_rdata;
  logic            tgt_we, qry_we;
  logic [SAW-1:0]  tgt_waddr, qry_waddr, tgt_raddr, qry_raddr;
  logic [7:0]      tgt_rdata, qry_rdata;
  logic            col_we;
  logic [15:0]     col_wdata, col_rdata;
  logic [CAW-1:0]  col_raddr;

  logic signed [SB-1:0] um, ug;
  logic signed [SB-1:0] cm, cg;
  logic signed [7:0]    ps;
  logic [AW-1:0]        c_fill;
  logic [LW-1:0]        fim1, fjm1, tim1, tjm1;
  logic                 in_acc;
  logic                 diag_mode;

  // Traceback step
  logic signed [SB-1:0] s0, s1, s2, s3, bval;
  logic [1:0]           bsel;
  logic                 nx_inm;
  logic [7:0]           qc, tc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign c_fill     = rb_q + AW'(fj_q);
  assign fim1       = fi_q - LW'(1);
  assign fjm1       = fj_q - LW'(1);
  assign tim1       = ti_q - LW'(1);
  assign tjm1       = tj_q - LW'(1);
  assign um         = $signed(tbl_rdata[2*SB-1:SB]);
  assign ug         = $signed(tbl_rdata[SB-1:0]);
  assign diag_mode  = inm_q && (ti_q != '0) && (tj_q != '0);

  // Memory address selection
  always_comb begin
    tbl_raddr = '0;
    tgt_raddr = '0;
    qry_raddr = '0;
    col_raddr = k_q;
    unique case (state_q)
      S_FILL_RD: begin
        tbl_raddr = (fi_q != '0) ? (c_fill - AW'(DIM)) : '0;
        tgt_raddr = fjm1[SAW-1:0];
        qry_raddr = fim1[SAW-1:0];
      end
      S_TB_INIT: tbl_raddr = tc_q;
      S_TB_RD1: begin
        if (diag_mode) begin
          tbl_raddr = tc_q - AW'(DIM + 1);
        end else if (tj_q != '0) begin
          tbl_raddr = tc_q - AW'(1);
        end
        tgt_raddr = tjm1[SAW-1:0];
        qry_raddr = tim1[SAW-1:0];
      end
      S_TB_RD2: tbl_raddr = (ti_q != '0) ? (tc_q - AW'(DIM)) : '0;
      default: ;
    endcase
  end

  // Pair score for the current cell
  always_comb begin
    case (aga_pkg::pair_class(tgt_rdata, qry_rdata, iupac_q))
      aga_pkg::PAIR_MATCH:   ps = match_q;
      aga_pkg::PAIR_PARTIAL: ps = partial_q;
      default:               ps = mismatch_q;
    endcase
  end

  // Cell update: corner, edges, interior
  always_comb begin
    if (fi_q == '0 && fj_q == '0) begin
      cm = SZERO;
      cg = SMIN;
    end else if (fi_q == '0) begin
      cm = SMIN;
      cg = (fj_q == LW'(1)) ? sat_add(SZERO, open_q) : sat_add(lg_q, ext_q);
    end else if (fj_q == '0) begin
      cm = SMIN;
      cg = (fi_q == LW'(1)) ? sat_add(SZERO, open_q) : sat_add(ug, ext_q);
    end else begin
      cm = sat_add(max2(dm_q, dg_q), ps);
      cg = max2(max2(max2(sat_add(lm_q, open_q), sat_add(lg_q, ext_q)),
                     sat_add(um, open_q)), sat_add(ug, ext_q));
    end
  end

  assign tbl_we    = (state_q == S_FILL_WR);
  assign tbl_waddr = c_fill;
  assign tbl_wdata = {cm, cg};

  // Traceback: diagonal from an inner match cell, else first strictly largest
  // of left-match, left-gap, up-match, up-gap among moves inside the table
  always_comb begin
    s0 = sat_add(r1m_q, open_q);
    s1 = sat_add(r1g_q, ext_q);
    s2 = sat_add(um, open_q);
    s3 = sat_add(ug, ext_q);
    bsel = 2'd0;
    bval = s0;
    if (tj_q != '0) begin
      if (s1 > bval) begin
        bsel = 2'd1;
        bval = s1;
      end
    end
    if (ti_q != '0) begin
      if (tj_q == '0 || s2 > bval) begin
        bsel = 2'd2;
        bval = s2;
      end
      if (s3 > bval) begin
        bsel = 2'd3;
        bval = s3;
      end
    end
    if (diag_mode) begin
      nx_inm = (r1m_q >= r1g_q);
      qc     = qb_q;
      tc     = tb_q;
    end else begin
      nx_inm = (bsel == 2'd0) || (bsel == 2'd2);
      qc     = (bsel <= 2'd1) ? aga_pkg::GAP_CHAR : qb_q;
      tc     = (bsel <= 2'd1) ? tb_q : aga_pkg::GAP_CHAR;
    end
  end

  assign col_we    = (state_q == S_TB_STEP);
  assign col_wdata = {qc, tc};

  assign tgt_we    = in_acc && (in_data_i.op == aga_pkg::OP_TARGET) &&
                     (tcount_q < LW'(MAX_LEN));
  assign qry_we    = in_acc && (in_data_i.op == aga_pkg::OP_QUERY) &&
                     (qcount_q < LW'(MAX_LEN));
  assign tgt_waddr = tcount_q[SAW-1:0];
  assign qry_waddr = qcount_q[SAW-1:0];

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.op == aga_pkg::OP_ALIGN) begin
          state_d = S_FILL_RD;
        end
      end
      S_FILL_RD: state_d = S_FILL_WR;
      S_FILL_WR: begin
        if (fj_q == nj_q && fi_q == ni_q) begin
          state_d = S_TB_INIT;
        end else begin
          state_d = S_FILL_RD;
        end
      end
      S_TB_INIT: state_d = S_TB_SEED;
      S_TB_SEED: state_d = S_TB_RD1;
      S_TB_RD1: begin
        if (ti_q == '0 && tj_q == '0) begin
          state_d = (n_q == '0) ? S_IDLE : S_EM_RD;
        end else begin
          state_d = S_TB_RD2;
        end
      end
      S_TB_RD2:  state_d = S_TB_STEP;
      S_TB_STEP: state_d = S_TB_RD1;
      S_EM_RD:   state_d = S_EM_LD;
      S_EM_LD:   state_d = S_EM_OUT;
      S_EM_OUT: begin
        if (!out_stall_i) begin
          state_d = (k_q == '0) ? S_IDLE : S_EM_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      match_q     <= 8'sd0;
      mismatch_q  <= -8'sd4;
      open_q      <= -8'sd4;
      ext_q       <= -8'sd2;
      partial_q   <= -8'sd1;
      iupac_q     <= 1'b0;
      tcount_q    <= '0;
      qcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (aga_pkg::cfg_e'(cfg_idx_i))
          aga_pkg::CFG_MATCH:    match_q    <= $signed(cfg_data_i);
          aga_pkg::CFG_MISMATCH: mismatch_q <= $signed(cfg_data_i);
          aga_pkg::CFG_GAP_OPEN: open_q     <= $signed(cfg_data_i);
          aga_pkg::CFG_GAP_EXT:  ext_q      <= $signed(cfg_data_i);
          aga_pkg::CFG_PARTIAL:  partial_q  <= $signed(cfg_data_i);
          aga_pkg::CFG_IUPAC:    iupac_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (tgt_we) begin
        tcount_q <= tcount_q + LW'(1);
      end
      if (qry_we) begin
        qcount_q <= qcount_q + LW'(1);
      end
      if (state_q == S_EM_LD) begin
        out_valid_q <= 1'b1;
      end else if (state_q == S_EM_OUT && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        ni_q <= qcount_q;
        nj_q <= tcount_q;
        fi_q <= '0;
        fj_q <= '0;
        rb_q <= '0;
      end
      S_FILL_WR: begin
        lm_q <= cm;
        lg_q <= cg;
        dm_q <= um;
        dg_q <= ug;
        if (fj_q == nj_q) begin
          if (fi_q == ni_q) begin
            // Hold the final cell position as the traceback start
            ti_q <= ni_q;
            tj_q <= nj_q;
            tc_q <= c_fill;
            n_q  <= '0;
          end else begin
            fi_q <= fi_q + LW'(1);
            fj_q <= '0;
            rb_q <= rb_q + AW'(DIM);
          end
        end else begin
          fj_q <= fj_q + LW'(1);
        end
      end
      S_TB_SEED: inm_q <= (um >= ug);
      S_TB_RD1: k_q <= CAW'(n_q - (CAW+1)'(1));
      S_TB_RD2: begin
        r1m_q <= um;
        r1g_q <= ug;
        qb_q  <= qry_rdata;
        tb_q  <= tgt_rdata;
      end
      S_TB_STEP: begin
        inm_q <= nx_inm;
        n_q   <= n_q + (CAW+1)'(1);
        if (diag_mode) begin
          ti_q <= tim1;
          tj_q <= tjm1;
          tc_q <= tc_q - AW'(DIM + 1);
        end else if (bsel <= 2'd1) begin
          tj_q <= tjm1;
          tc_q <= tc_q - AW'(1);
        end else begin
          ti_q <= tim1;
          tc_q <= tc_q - AW'(DIM);
        end
      end
      S_EM_LD: begin
        out_q.query_column  <= col_rdata[15:8];
        out_q.target_column <= col_rdata[7:0];
        out_q.last_column   <= (k_q == '0);
      end
      S_EM_OUT: begin
        if (!out_stall_i && k_q != '0) begin
          k_q <= k_q - CAW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  aga_ram #(.AW(AW), .WIDTH(2 * SB)) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  aga_ram #(.AW(SAW), .WIDTH(8)) u_target (
    .clk_i  (clk_i),
    .we_i   (tgt_we),
    .waddr_i(tgt_waddr),
    .wdata_i(in_data_i.base),
    .raddr_i(tgt_raddr),
    .rdata_o(tgt_rdata)
  );

  aga_ram #(.AW(SAW), .WIDTH(8)) u_query (
    .clk_i  (clk_i),
    .we_i   (qry_we),
    .waddr_i(qry_waddr),
    .wdata_i(in_data_i.base),
    .raddr_i(qry_raddr),
    .rdata_o(qry_rdata)
  );

  aga_ram #(.AW(CAW), .WIDTH(16)) u_columns (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .waddr_i(n_q[CAW-1:0]),
    .wdata_i(col_wdata),
    .raddr_i(col_raddr),
    .rdata_o(col_rdata)
  );

endmodule
